// ===== src/sbht_pkg.sv =====
// Package for the swept box hit time block.
// Holds the slab front end's compare-result type and the divider row's control struct.
// No dependencies.
package sbht_pkg;

  // Rational compare outcome
  typedef enum logic [1:0] {
    CMP_LT = 2'd0,
    CMP_EQ = 2'd1,
    CMP_GT = 2'd2
  } cmp_t;

  // Control that travels with an item down the divider row
  typedef struct packed {
    logic hit;
    logic normal_on_y;
    logic normal_negative;
  } sbht_ctl_t;

endpackage

// ===== src/sbht_div_cell.sv =====
// One restoring-division cell of the entry-time divider row.
// Produces one quotient bit per cell and hands remainder, divisor and flags on.
// Depends on sbht_pkg.
module sbht_div_cell #(
  parameter int RW = 28,
  parameter int QW = 17
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [RW-1:0]          in_rem,
  input  logic [RW-1:0]          in_den,
  input  logic [QW-1:0]          in_q,
  input  sbht_pkg::sbht_ctl_t    in_ctl,
  output logic                   out_valid,
  output logic [RW-1:0]          out_rem,
  output logic [RW-1:0]          out_den,
  output logic [QW-1:0]          out_q,
  output sbht_pkg::sbht_ctl_t    out_ctl
);

  logic [RW:0] shifted;
  logic        take;

  // shift remainder, compare, subtract
  assign shifted = {in_rem, 1'b0};
  assign take    = shifted >= {1'b0, in_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rem <= take ? RW'(shifted - {1'b0, in_den}) : RW'(shifted);
      out_den <= in_den;
      out_q   <= {in_q[QW-2:0], take};
      out_ctl <= in_ctl;
    end
  end

endmodule

// ===== src/sbht_slab.sv =====
// Slab front end: widens the still box, forms near/far per axis, compares
// them by cross multiplication and picks the entry time in registered stages.
// Depends on sbht_pkg.
module sbht_slab #(
  parameter int CW = 24,
  parameter int RW = CW + 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [CW-1:0]        still_centre_x,
  input  logic [CW-1:0]        still_centre_y,
  input  logic [CW-3:0]        still_half_x,
  input  logic [CW-3:0]        still_half_y,
  input  logic [CW-1:0]        mover_centre_x,
  input  logic [CW-1:0]        mover_centre_y,
  input  logic [CW-3:0]        mover_half_x,
  input  logic [CW-3:0]        mover_half_y,
  input  logic [CW-1:0]        move_x,
  input  logic [CW-1:0]        move_y,
  output logic                 out_valid,
  output logic [RW-1:0]        out_num,
  output logic [RW-1:0]        out_den,
  output logic                 out_ge1,
  output sbht_pkg::sbht_ctl_t  out_ctl
);

  localparam int NW = CW + 3;   // signed near/far numerator width
  localparam int PW = NW + CW;  // product width

  // ---- stage 1: numerators and magnitudes ----
  function automatic logic signed [NW-1:0] sx(input logic [CW-1:0] v);
    return NW'($signed(v));
  endfunction

  logic signed [NW-1:0] hx, hy, px, py, nxn, fxn, nyn, fyn;
  logic [CW-1:0]        mx, my;
  logic                 zx, zy, inx, iny;

  always_comb begin
    hx = NW'({1'b0, still_half_x}) + NW'({1'b0, mover_half_x});
    hy = NW'({1'b0, still_half_y}) + NW'({1'b0, mover_half_y});
    px = move_x[CW-1] ? sx(mover_centre_x) - sx(still_centre_x)
                      : sx(still_centre_x) - sx(mover_centre_x);
    py = move_y[CW-1] ? sx(mover_centre_y) - sx(still_centre_y)
                      : sx(still_centre_y) - sx(mover_centre_y);
    nxn = px - hx;
    fxn = px + hx;
    nyn = py - hy;
    fyn = py + hy;
    mx  = move_x[CW-1] ? CW'(-move_x) : move_x;
    my  = move_y[CW-1] ? CW'(-move_y) : move_y;
    zx  = (move_x == '0);
    zy  = (move_y == '0);
    // with zero motion px = still - mover; inside when |px| <= h
    inx = (nxn <= 0) && (fxn >= 0);
    iny = (nyn <= 0) && (fyn >= 0);
  end

  logic                 v1;
  logic signed [NW-1:0] nx1, fx1, ny1, fy1;
  logic [CW-1:0]        mx1, my1;
  logic                 zx1, zy1, ok1, sgx1, sgy1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx1 <= nxn; fx1 <= fxn; ny1 <= nyn; fy1 <= fyn;
      mx1 <= mx;  my1 <= my;  zx1 <= zx;  zy1 <= zy;
      ok1 <= (!zx || inx) && (!zy || iny);
      sgx1 <= !move_x[CW-1];
      sgy1 <= !move_y[CW-1];
    end
  end

  // ---- stage 2: cross products (one multiplier each, registered) ----
  logic signed [PW:0] a_nxfy, b_nxfy, a_nyfx, b_nyfx, a_nxny, b_nxny;
  logic signed [PW:0] a_fxfy, b_fxfy;

  function automatic logic signed [PW:0] mul(input logic signed [NW-1:0] n,
                                            input logic [CW-1:0] d);
    return (PW+1)'(n) * (PW+1)'($signed({1'b0, d}));
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      a_nxfy <= mul(nx1, my1); b_nxfy <= mul(fy1, mx1);
      a_nyfx <= mul(ny1, mx1); b_nyfx <= mul(fx1, my1);
      a_nxny <= mul(nx1, my1); b_nxny <= mul(ny1, mx1);
      a_fxfy <= mul(fx1, my1); b_fxfy <= mul(fy1, mx1);
    end
  end

  logic                 v2, zx2, zy2, ok2, sgx2, sgy2;
  logic signed [NW-1:0] nx2, fx2, ny2, fy2;
  logic [CW-1:0]        mx2, my2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx2 <= nx1; fx2 <= fx1; ny2 <= ny1; fy2 <= fy1;
      mx2 <= mx1; my2 <= my1; zx2 <= zx1; zy2 <= zy1;
      ok2 <= ok1; sgx2 <= sgx1; sgy2 <= sgy1;
    end
  end

  // ---- decision: compare with infinities folded in ----
  // zero motion makes near = -inf and far = +inf on that axis
  sbht_pkg::cmp_t c_nxfy, c_nyfx, c_nxny, c_fxfy;

  function automatic sbht_pkg::cmp_t pc(input logic signed [PW:0] a,
                                        input logic signed [PW:0] b);
    if (a > b) return sbht_pkg::CMP_GT;
    if (a < b) return sbht_pkg::CMP_LT;
    return sbht_pkg::CMP_EQ;
  endfunction

  logic nxgt1, nygt1, fxlt0, fylt0, on_y, hit_c, neg_c, ge1;
  logic signed [NW-1:0] nsel;
  logic [CW-1:0]        dsel;
  logic                 near_inf;

  always_comb begin
    // both finite: a/ma vs b/mb ~ a*mb vs b*ma
    c_nxfy = (zx2 || zy2) ? sbht_pkg::CMP_LT : pc(a_nxfy, b_nxfy);
    c_nyfx = (zx2 || zy2) ? sbht_pkg::CMP_LT : pc(a_nyfx, b_nyfx);
    if (zx2 && zy2)      c_nxny = sbht_pkg::CMP_EQ;
    else if (zx2)        c_nxny = sbht_pkg::CMP_LT;
    else if (zy2)        c_nxny = sbht_pkg::CMP_GT;
    else                 c_nxny = pc(a_nxny, b_nxny);
    if (zx2 && zy2)      c_fxfy = sbht_pkg::CMP_EQ;
    else if (zx2)        c_fxfy = sbht_pkg::CMP_GT;
    else if (zy2)        c_fxfy = sbht_pkg::CMP_LT;
    else                 c_fxfy = pc(a_fxfy, b_fxfy);
    on_y  = (c_nxny != sbht_pkg::CMP_GT);
    nxgt1 = !zx2 && (nx2 > $signed({3'b0, mx2}));
    nygt1 = !zy2 && (ny2 > $signed({3'b0, my2}));
    fxlt0 = !zx2 && (fx2 < 0);
    fylt0 = !zy2 && (fy2 < 0);
    nsel  = on_y ? ny2 : nx2;
    dsel  = on_y ? my2 : mx2;
    near_inf = on_y ? zy2 : zx2;
    hit_c = ok2 && (c_nxfy != sbht_pkg::CMP_GT) && (c_nyfx != sbht_pkg::CMP_GT)
            && !(on_y ? nygt1 : nxgt1)
            && !((c_fxfy == sbht_pkg::CMP_LT) ? fxlt0 : fylt0);
    neg_c = on_y ? sgy2 : sgx2;
    ge1   = !near_inf && (nsel >= $signed({3'b0, dsel})) && (nsel > 0);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // remainder = near numerator (or near - den when >= 1), 0 when near <= 0, infinite or no hit
      if (!hit_c || near_inf || nsel <= 0) begin
        out_num <= '0;
      end else if (ge1) begin
        out_num <= RW'(nsel - $signed({3'b0, dsel}));
      end else begin
        out_num <= RW'(nsel);
      end
      out_den <= RW'(dsel) | RW'(near_inf);
      out_ge1 <= hit_c && ge1;
      out_ctl.hit             <= hit_c;
      out_ctl.normal_on_y     <= hit_c && on_y;
      out_ctl.normal_negative <= hit_c && neg_c;
    end
  end

endmodule

// ===== src/swept_box_hit_time.sv =====
// Swept box hit time: top level.
// Slab front end followed by a row of divider cells and an output register.
// Depends on sbht_pkg, sbht_slab, sbht_div_cell.
//
// Usage: one beat on the input channel carries a stationary box, a moving
// box and the motion vector; centres and motion signed Q16.8, halves
// unsigned Q14.8. One result beat comes back per input beat, in order:
// hit, normal_on_y, normal_negative, hit_time (Q1.16, 1.0 = 2^TIME_FRAC_BITS,
// rounded down, 0 when there is no hit). Throughput: one beat per cycle
// while the receiver does not stall. An item passes three slab stages,
// one divider cell per quotient fraction bit and one output register.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, the pipeline freezes and in_ready drops. Bubbles in the
// row are not squeezed out, so ready is high exactly while the output slot
// is empty or its result is being taken.
// Reset clears every valid flag; no item is in flight afterwards.
module swept_box_hit_time #(
  parameter int COORD_BITS     = 24,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   still_centre_x,
  input  logic [COORD_BITS-1:0]   still_centre_y,
  input  logic [COORD_BITS-3:0]   still_half_x,
  input  logic [COORD_BITS-3:0]   still_half_y,
  input  logic [COORD_BITS-1:0]   mover_centre_x,
  input  logic [COORD_BITS-1:0]   mover_centre_y,
  input  logic [COORD_BITS-3:0]   mover_half_x,
  input  logic [COORD_BITS-3:0]   mover_half_y,
  input  logic [COORD_BITS-1:0]   move_x,
  input  logic [COORD_BITS-1:0]   move_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit,
  output logic                    normal_on_y,
  output logic                    normal_negative,
  output logic [TIME_FRAC_BITS:0] hit_time
);

  localparam int RW = COORD_BITS + 4;
  localparam int QW = TIME_FRAC_BITS + 1;
  localparam int N  = TIME_FRAC_BITS;

  logic adv;

  // output register frees when taken; whole row moves on adv
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic                s_valid;
  logic [RW-1:0]       s_num, s_den;
  logic                s_ge1;
  sbht_pkg::sbht_ctl_t s_ctl;

  sbht_slab #(.CW(COORD_BITS), .RW(RW)) u_slab (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(in_valid && in_ready),
    .still_centre_x(still_centre_x), .still_centre_y(still_centre_y),
    .still_half_x(still_half_x), .still_half_y(still_half_y),
    .mover_centre_x(mover_centre_x), .mover_centre_y(mover_centre_y),
    .mover_half_x(mover_half_x), .mover_half_y(mover_half_y),
    .move_x(move_x), .move_y(move_y),
    .out_valid(s_valid), .out_num(s_num), .out_den(s_den),
    .out_ge1(s_ge1), .out_ctl(s_ctl)
  );

  // divider row: one quotient bit per cell
  logic                v_c [N+1];
  logic [RW-1:0]       r_c [N+1];
  logic [RW-1:0]       d_c [N+1];
  logic [QW-1:0]       q_c [N+1];
  sbht_pkg::sbht_ctl_t k_c [N+1];

  assign v_c[0] = s_valid;
  assign r_c[0] = s_num;
  assign d_c[0] = s_den;
  assign q_c[0] = QW'(s_ge1);
  assign k_c[0] = s_ctl;

  for (genvar g = 0; g < N; g++) begin : g_cell
    sbht_div_cell #(.RW(RW), .QW(QW)) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .in_valid(v_c[g]), .in_rem(r_c[g]), .in_den(d_c[g]),
      .in_q(q_c[g]), .in_ctl(k_c[g]),
      .out_valid(v_c[g+1]), .out_rem(r_c[g+1]), .out_den(d_c[g+1]),
      .out_q(q_c[g+1]), .out_ctl(k_c[g+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v_c[N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit             <= k_c[N].hit;
      normal_on_y     <= k_c[N].normal_on_y;
      normal_negative <= k_c[N].normal_negative;
      hit_time        <= k_c[N].hit ? q_c[N] : '0;
    end
  end

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit_time))
    else $error("result changed under stall");
  // no fields without a hit
  a_nohit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> !normal_on_y && !normal_negative && hit_time == '0)
    else $error("fields set without hit");
  // time never above 1.0
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_time[TIME_FRAC_BITS] |-> hit_time[TIME_FRAC_BITS-1:0] == '0)
    else $error("hit_time above one");

endmodule

// ===== test/swept_box_hit_time_test.sv =====
`timescale 1ns / 100ps
// Testbench for swept_box_hit_time: directed box pairs, then random pairs; each result
// checked against a typed row or an exact rational slab predictor. Depends on sbht_pkg.
module swept_box_hit_time_test;

  localparam int CB      = 24;
  localparam int TF      = 16;
  localparam int LATENCY = 4 + TF;
  localparam int N_RAND  = 750;
  localparam int QUIET   = 120;

  typedef struct {
    logic [CB-1:0] sc_x, sc_y;
    logic [CB-3:0] sh_x, sh_y;
    logic [CB-1:0] mc_x, mc_y;
    logic [CB-3:0] mh_x, mh_y;
    logic [CB-1:0] mv_x, mv_y;
  } pair_t;

  typedef struct {
    logic          hit;
    logic          on_y;
    logic          neg;
    logic [TF:0]   t;
  } contact_t;

  typedef struct {
    pair_t    p;
    bit       typed;
    contact_t want;
  } row_t;

  // time as num/den, den == 0 is infinity with the sign of num
  typedef struct {
    longint num;
    longint den;
  } ratio_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [CB-1:0] still_centre_x = 0, still_centre_y = 0;
  logic [CB-3:0] still_half_x = 0, still_half_y = 0;
  logic [CB-1:0] mover_centre_x = 0, mover_centre_y = 0;
  logic [CB-3:0] mover_half_x = 0, mover_half_y = 0;
  logic [CB-1:0] move_x = 0, move_y = 0;
  logic out_valid;
  logic out_ready = 1;
  logic hit, normal_on_y, normal_negative;
  logic [TF:0] hit_time;

  contact_t pending_contacts[$];
  int  mismatches = 0;
  int  errors = 0;
  int  hits_seen = 0;
  int  results_seen = 0;
  int  sent = 0;
  bit  quiet = 0;
  bit  done_sending = 0;

  swept_box_hit_time u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .still_centre_x(still_centre_x), .still_centre_y(still_centre_y),
    .still_half_x(still_half_x), .still_half_y(still_half_y),
    .mover_centre_x(mover_centre_x), .mover_centre_y(mover_centre_y),
    .mover_half_x(mover_half_x), .mover_half_y(mover_half_y),
    .move_x(move_x), .move_y(move_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .normal_on_y(normal_on_y), .normal_negative(normal_negative),
    .hit_time(hit_time)
  );

  always #4 clk = ~clk;

  // exact compare of two times
  function automatic sbht_pkg::cmp_t ratio_cmp(ratio_t a, ratio_t b);
    longint l, r;
    if (a.den == 0 && b.den == 0) begin
      if ((a.num > 0) == (b.num > 0)) return sbht_pkg::CMP_EQ;
      return (a.num > 0) ? sbht_pkg::CMP_GT : sbht_pkg::CMP_LT;
    end
    if (a.den == 0) return (a.num > 0) ? sbht_pkg::CMP_GT : sbht_pkg::CMP_LT;
    if (b.den == 0) return (b.num > 0) ? sbht_pkg::CMP_LT : sbht_pkg::CMP_GT;
    l = a.num * b.den;
    r = b.num * a.den;
    if (l > r) return sbht_pkg::CMP_GT;
    if (l < r) return sbht_pkg::CMP_LT;
    return sbht_pkg::CMP_EQ;
  endfunction

  // one axis; returns 0 when this axis alone rules out contact
  function automatic bit axis_slab(logic [CB-1:0] sc, logic [CB-3:0] sh, logic [CB-1:0] mc,
                                   logic [CB-3:0] mh, logic [CB-1:0] mv,
                                   output ratio_t nr, output ratio_t fr);
    longint o, s, d, h, p, m;
    o = longint'($signed(sc));
    s = longint'($signed(mc));
    d = longint'($signed(mv));
    h = longint'(sh) + longint'(mh);
    if (d == 0) begin
      nr = '{-1, 0};
      fr = '{1, 0};
      return (s >= o - h) && (s <= o + h);
    end
    if (d > 0) begin
      p = o - s; m = d;
    end else begin
      p = s - o; m = -d;
    end
    nr = '{p - h, m};
    fr = '{p + h, m};
    return 1;
  endfunction

  // swept contact of one box pair
  function automatic contact_t sweep_contact(pair_t p);
    ratio_t nx, fx, ny, fy, near_t, far_t;
    bit okx, oky, pick_y;
    longint q;
    contact_t c;
    c = '{0, 0, 0, 0};
    okx = axis_slab(p.sc_x, p.sh_x, p.mc_x, p.mh_x, p.mv_x, nx, fx);
    oky = axis_slab(p.sc_y, p.sh_y, p.mc_y, p.mh_y, p.mv_y, ny, fy);
    if (!okx || !oky) return c;
    if (ratio_cmp(nx, fy) == sbht_pkg::CMP_GT || ratio_cmp(ny, fx) == sbht_pkg::CMP_GT)
      return c;
    pick_y = ratio_cmp(nx, ny) != sbht_pkg::CMP_GT;
    near_t = pick_y ? ny : nx;
    far_t = (ratio_cmp(fx, fy) == sbht_pkg::CMP_LT) ? fx : fy;
    if (ratio_cmp(near_t, '{1, 1}) == sbht_pkg::CMP_GT ||
        ratio_cmp(far_t, '{0, 1}) == sbht_pkg::CMP_LT) return c;
    q = 0;
    if (near_t.den != 0 && near_t.num > 0) q = (near_t.num << TF) / near_t.den;
    c.hit = 1;
    c.on_y = pick_y;
    c.neg = ($signed(pick_y ? p.mv_y : p.mv_x) >= 0);
    c.t = q[TF:0];
    return c;
  endfunction

  function automatic pair_t mk(longint scx, longint scy, longint shx, longint shy,
                               longint mcx, longint mcy, longint mhx, longint mhy,
                               longint mvx, longint mvy);
    pair_t p;
    p.sc_x = scx[CB-1:0]; p.sc_y = scy[CB-1:0];
    p.sh_x = shx[CB-3:0]; p.sh_y = shy[CB-3:0];
    p.mc_x = mcx[CB-1:0]; p.mc_y = mcy[CB-1:0];
    p.mh_x = mhx[CB-3:0]; p.mh_y = mhy[CB-3:0];
    p.mv_x = mvx[CB-1:0]; p.mv_y = mvy[CB-1:0];
    return p;
  endfunction

  function automatic longint spread(int lim);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // mostly pairs aimed at each other, the rest raw bits
  function automatic pair_t random_pair();
    pair_t p;
    longint ox, oy, dx, dy;
    if ($urandom_range(0, 3) == 0) begin
      p.sc_x = CB'($urandom); p.sc_y = CB'($urandom);
      p.sh_x = (CB-2)'($urandom); p.sh_y = (CB-2)'($urandom);
      p.mc_x = CB'($urandom); p.mc_y = CB'($urandom);
      p.mh_x = (CB-2)'($urandom); p.mh_y = (CB-2)'($urandom);
      p.mv_x = CB'($urandom); p.mv_y = CB'($urandom);
      if ($urandom_range(0, 3) == 0) p.mv_x = 0;
      if ($urandom_range(0, 3) == 0) p.mv_y = 0;
      return p;
    end
    ox = spread(30000);
    oy = spread(30000);
    dx = -ox + spread(8000);
    dy = -oy + spread(8000);
    if ($urandom_range(0, 7) == 0) dx = 0;
    if ($urandom_range(0, 7) == 0) dy = 0;
    if ($urandom_range(0, 5) == 0) dx = dx * 2;
    return mk(spread(4000000), 0, $urandom_range(0, 5000), $urandom_range(0, 5000),
              0, 0, $urandom_range(0, 5000), $urandom_range(0, 5000), dx, dy)
           ;
  endfunction

  // build a well-formed pair by offsetting the mover from the still box; raw pairs pass through
  function automatic pair_t aimed_pair();
    pair_t p;
    longint cx, cy;
    p = random_pair();
    if (p.sc_y != 0 || p.mc_x != 0) return p;
    cx = longint'($signed(p.sc_x));
    cy = spread(4000000);
    p.sc_y = cy[CB-1:0];
    cx = cx + spread(30000);
    p.mc_x = cx[CB-1:0];
    cy = cy + spread(30000);
    p.mc_y = cy[CB-1:0];
    cx = longint'($signed(p.sc_x)) - cx + spread(6000);
    cy = longint'($signed(p.sc_y)) - cy + spread(6000);
    if ($urandom_range(0, 7) != 0) p.mv_x = cx[CB-1:0];
    if ($urandom_range(0, 7) != 0) p.mv_y = cy[CB-1:0];
    return p;
  endfunction

  task automatic send_beat(pair_t p, contact_t want);
    in_valid <= 1;
    still_centre_x <= p.sc_x; still_centre_y <= p.sc_y;
    still_half_x <= p.sh_x; still_half_y <= p.sh_y;
    mover_centre_x <= p.mc_x; mover_centre_y <= p.mc_y;
    mover_half_x <= p.mh_x; mover_half_y <= p.mh_y;
    move_x <= p.mv_x; move_y <= p.mv_y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_contacts.push_back(want);
    sent++;
    // sender gap
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // stimulus
  initial begin
    row_t rows[$];
    pair_t p;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // both axes still, start at the center: inside, y picked on the tie
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{1, 1, 1, 0}});
    // still on x and outside the slab
    rows.push_back('{mk(0, 0, 0, 0, 1000, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 0}});
    // still, start exactly on the widened boundary
    rows.push_back('{mk(0, 0, 100, 50, 300, -50, 200, 0, 0, 0), 1, '{1, 1, 1, 0}});
    // entry exactly at the end of the step
    rows.push_back('{mk(0, 0, 0, 0, -1000, 0, 0, 0, 1000, 0), 1, '{1, 0, 1, 17'h10000}});
    // entry at half the step, positive and negative motion
    rows.push_back('{mk(0, 0, 0, 0, -1000, 0, 0, 0, 2000, 0), 1, '{1, 0, 1, 17'h08000}});
    rows.push_back('{mk(0, 0, 0, 0, 1000, 0, 0, 0, -2000, 0), 1, '{1, 0, 0, 17'h08000}});
    // diagonal tie between entry times
    rows.push_back('{mk(0, 0, 0, 0, -1000, -1000, 0, 0, 2000, 2000), 1,
                     '{1, 1, 1, 17'h08000}});
    // moving away, already past
    rows.push_back('{mk(0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0), 1, '{0, 0, 0, 0}});
    // entry after the step
    rows.push_back('{mk(0, 0, 0, 0, -3000, 0, 0, 0, 1000, 0), 1, '{0, 0, 0, 0}});
    // starting inside while moving: entry clamps to zero
    rows.push_back('{mk(0, 0, 100, 0, 0, 0, 0, 0, 500, 0), 1, '{1, 0, 1, 0}});
    // extremes of the fields
    rows.push_back('{mk(8388607, -8388608, 4194303, 4194303, -8388608, 8388607,
                        4194303, 4194303, 8388607, -8388608), 0, '{0, 0, 0, 0}});
    rows.push_back('{mk(-8388608, 8388607, 4194303, 0, 8388607, -8388608,
                        0, 4194303, -8388608, 8388607), 0, '{0, 0, 0, 0}});
    rows.push_back('{mk(8388607, 8388607, 0, 0, -8388608, -8388608,
                        0, 0, 8388607, 8388607), 0, '{0, 0, 0, 0}});
    rows.push_back('{mk(-8388608, -8388608, 4194303, 4194303, -8388608, -8388608,
                        4194303, 4194303, -8388608, -8388608), 0, '{0, 0, 0, 0}});
    rows.push_back('{mk(0, 0, 0, 0, -1, 0, 0, 0, 3, 0), 0, '{0, 0, 0, 0}});
    rows.push_back('{mk(0, 0, 7, 0, -8388608, 0, 0, 1, 8388607, -1), 0, '{0, 0, 0, 0}});
    rows.push_back('{mk(10, -20, 3, 9, -500, 400, 2, 1, 700, -650), 0, '{0, 0, 0, 0}});

    foreach (rows[i])
      send_beat(rows[i].p, rows[i].typed ? rows[i].want : sweep_contact(rows[i].p));

    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND - QUIET) quiet = 1;
      p = aimed_pair();
      send_beat(p, sweep_contact(p));
    end
    in_valid <= 0;
    done_sending = 1;
  end

  // result side: check and stall the receiver
  always @(posedge clk) begin
    contact_t want;
    int stall_left;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_contacts.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("result beat with nothing expected at %0t", $time);
      end else begin
        want = pending_contacts.pop_front();
        if (want.hit) hits_seen++;
        if (hit !== want.hit || normal_on_y !== want.on_y ||
            normal_negative !== want.neg || hit_time !== want.t) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch at %0t: want hit=%0d y=%0d neg=%0d t=%0d, got %0d %0d %0d %0d",
                     $time, want.hit, want.on_y, want.neg, want.t,
                     hit, normal_on_y, normal_negative, hit_time);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else if (!quiet && $urandom_range(0, 19) == 0) begin
      stall_left = $urandom_range(1, 17);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // end of run
  initial begin
    wait (done_sending);
    while (pending_contacts.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (pending_contacts.size() != 0) errors++;
    $display("sent %0d box pairs (directed and random), %0d results, %0d hits",
             sent, results_seen, hits_seen);
    $display("sender gaps and receiver stalls until a clean streaming tail; %0d mismatches",
             mismatches);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== swept_box_hit_time.f =====
src/sbht_pkg.sv
src/sbht_div_cell.sv
src/sbht_slab.sv
src/swept_box_hit_time.sv
test/swept_box_hit_time_test.sv
